>>> rtl/ctb_pkg.sv
// Package for the C-style byte tokenizer: widths, class and error codes,
// payload structs and the byte classifier. No dependencies.
package ctb_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;
    localparam int LEN_BITS    = OFFSET_BITS + 1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;

    typedef enum logic [2:0] {
        CL_UNDEF = 3'd0,
        CL_SEP   = 3'd1,
        CL_OPER  = 3'd2,
        CL_CONST = 3'd3,
        CL_ID    = 3'd4,
        CL_STR   = 3'd5,
        CL_CHAR  = 3'd6
    } tok_class_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_STR  = 2'd1,
        ERR_CHAR = 2'd2
    } tok_err_t;

    typedef enum logic [1:0] {
        BRK_NONE = 2'd0,
        BRK_CR   = 2'd1,
        BRK_LF   = 2'd2
    } brk_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0]             file_tag;
        tok_class_t             token_class;
        logic [OFFSET_BITS-1:0] token_offset;
        logic [LINE_BITS-1:0]   token_line;
        logic [COLUMN_BITS-1:0] token_column;
        logic [LEN_BITS-1:0]    token_length;
        tok_err_t               error_code;
        logic                   last_of_run;
        logic                   file_done;
    } token_t;

    typedef struct packed {
        logic   push_a;
        logic   push_b;
        token_t tok_a;
        token_t tok_b;
    } push_t;

    function automatic tok_class_t ctb_classify(input logic [7:0] b);
        tok_class_t c;
        c = CL_UNDEF;
        unique case (b)
            8'h00, 8'h40, 8'h24, 8'h60, 8'h23, 8'h7B, 8'h7D, 8'h2C, 8'h7C, 8'h5B,
            8'h5D, 8'h2B, 8'h2D, 8'h25, 8'h3B, 8'h3A, 8'h3F, 8'h3C, 8'h3E, 8'h3D,
            8'h21, 8'h26, 8'h7E, 8'h5E, 8'h2A, 8'h5C, 8'h28, 8'h29, 8'h2F, 8'h2E:
                c = CL_OPER;
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D:
                c = CL_SEP;
            CHAR_DQUOTE:
                c = CL_STR;
            CHAR_SQUOTE:
                c = CL_CHAR;
            default:
            begin
                if (b >= 8'h30 && b <= 8'h39)
                    c = CL_CONST;
                else if (b == 8'h5F || (b >= 8'h41 && b <= 8'h5A) ||
                         (b >= 8'h61 && b <= 8'h7A))
                    c = CL_ID;
                else
                    c = CL_UNDEF;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/c_style_byte_tokenizer_top.sv
// C-style byte tokenizer, top level: source id register, scan stage, token queue.
// Depends on ctb_pkg, ctb_scan and ctb_token_fifo.
//
// Usage: bytes of a source file enter on in_valid/in_stall/in_data, one byte
// per transfer, with end_of_file set on the last byte. Tokens leave on
// out_valid/out_stall/out_data, one token per transfer. cfg_wr_en/cfg_wr_data
// write source_id, which is copied into each token's file_tag; write it only
// while the block is idle.
// Flow: a transferred byte is held in the byte register and processed from there
// once the queue has room; its tokens are written into the queue, which drives
// the output. Throughput: one byte per cycle while in_stall is low; each byte
// gives zero, one or two tokens, and the output moves one token per transfer,
// so bytes that close a token and start an operator put two tokens in the queue.
// The byte register is followed by a four-entry token queue; the byte register
// waits while fewer than two entries are free, and in_stall is raised when it
// is full and waiting. A stalled receiver only fills the queue.
// Reset clears the queue, the open token and the counters (offset 0, line 1,
// column 0) and sets source_id to 0. End of file restarts the counters.
module c_style_byte_tokenizer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ctb_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ctb_pkg::token_t   out_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import ctb_pkg::*;

    logic [7:0] source_id_reg;
    push_t      push;
    logic       room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            source_id_reg <= '0;
        else if (cfg_wr_en)
            source_id_reg <= cfg_wr_data;
    end

    ctb_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .source_id (source_id_reg),
        .room      (room),
        .push      (push)
    );

    ctb_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> rtl/ctb_scan.sv
// Input register and token logic: holds one byte, classifies it, tracks the
// open token and the position counters, and emits up to two tokens. Uses ctb_pkg.
module ctb_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ctb_pkg::in_item_t in_data,
    input  logic [7:0]        source_id,
    input  logic              room,
    output ctb_pkg::push_t    push
);
    import ctb_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]    LEN_MAX  = {1'b1, {OFFSET_BITS{1'b0}}};

    logic                   stage_valid_reg;
    in_item_t               stage_item_reg;

    logic                   active_reg, active_next;
    tok_class_t             open_class_reg, open_class_next;
    logic [OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [LINE_BITS-1:0]   start_line_reg, start_line_next;
    logic [COLUMN_BITS-1:0] start_column_reg, start_column_next;
    logic [LEN_BITS-1:0]    tok_len_reg, tok_len_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [LINE_BITS-1:0]   line_count_reg, line_count_next;
    logic [COLUMN_BITS-1:0] column_count_reg, column_count_next;
    brk_t                   brk_reg, brk_next;

    logic                   proceed;
    logic [7:0]             b;
    logic                   eof;
    tok_class_t             cls;
    logic                   is_lit;
    logic [7:0]             quote;
    tok_err_t               lit_err;
    logic                   consumed;
    logic                   quote_close;
    logic                   emit_a;
    logic                   emit_b;
    logic [LEN_BITS-1:0]    len_inc;
    logic                   line_break;

    assign proceed  = stage_valid_reg && room;
    assign in_stall = stage_valid_reg && !room;

    always_comb
    begin
        b       = stage_item_reg.data_byte;
        eof     = stage_item_reg.end_of_file;
        cls     = ctb_classify(b);
        is_lit  = (open_class_reg == CL_STR) || (open_class_reg == CL_CHAR);
        quote   = (open_class_reg == CL_STR) ? CHAR_DQUOTE : CHAR_SQUOTE;
        lit_err = (open_class_reg == CL_STR) ? ERR_STR :
                  (open_class_reg == CL_CHAR) ? ERR_CHAR : ERR_NONE;
        len_inc = (tok_len_reg == LEN_MAX) ? tok_len_reg : tok_len_reg + LEN_BITS'(1);

        consumed    = 1'b0;
        quote_close = 1'b0;
        if (active_reg)
        begin
            unique case (open_class_reg)
                CL_UNDEF, CL_SEP:
                    consumed = (cls == open_class_reg);
                CL_ID, CL_CONST:
                    consumed = (cls == CL_ID) || (cls == CL_CONST);
                CL_STR, CL_CHAR:
                begin
                    quote_close = (b == quote);
                    consumed    = (b != CHAR_LF);
                end
                default:
                    consumed = 1'b0;
            endcase
        end

        emit_a = active_reg && (!consumed || quote_close || eof);
        emit_b = !consumed && ((cls == CL_OPER) || eof);

        push.push_a             = proceed && emit_a;
        push.push_b             = proceed && emit_b;

        push.tok_a.file_tag     = source_id;
        push.tok_a.token_class  = open_class_reg;
        push.tok_a.token_offset = start_offset_reg;
        push.tok_a.token_line   = start_line_reg;
        push.tok_a.token_column = start_column_reg;
        push.tok_a.token_length = consumed ? len_inc : tok_len_reg;
        push.tok_a.error_code   = (is_lit && !quote_close) ? lit_err : ERR_NONE;
        push.tok_a.last_of_run  = !emit_b;
        push.tok_a.file_done    = eof && !emit_b;

        push.tok_b.file_tag     = source_id;
        push.tok_b.token_class  = cls;
        push.tok_b.token_offset = byte_offset_reg;
        push.tok_b.token_line   = line_count_reg;
        push.tok_b.token_column = column_count_reg;
        push.tok_b.token_length = LEN_BITS'(1);
        push.tok_b.error_code   = (cls == CL_STR) ? ERR_STR :
                                  (cls == CL_CHAR) ? ERR_CHAR : ERR_NONE;
        push.tok_b.last_of_run  = 1'b1;
        push.tok_b.file_done    = eof;

        if (!consumed)
        begin
            open_class_next   = cls;
            start_offset_next = byte_offset_reg;
            start_line_next   = line_count_reg;
            start_column_next = column_count_reg;
            tok_len_next      = LEN_BITS'(1);
            active_next       = !emit_b;
        end
        else
        begin
            open_class_next   = open_class_reg;
            start_offset_next = start_offset_reg;
            start_line_next   = start_line_reg;
            start_column_next = start_column_reg;
            tok_len_next      = len_inc;
            active_next       = !emit_a;
        end

        // CR LF and LF CR merge into one break
        byte_offset_next  = byte_offset_reg + OFFSET_BITS'(1);
        line_count_next   = line_count_reg;
        column_count_next = column_count_reg;
        brk_next          = BRK_NONE;
        line_break        = 1'b0;
        if (b == CHAR_CR)
        begin
            if (brk_reg != BRK_LF)
            begin
                line_break = 1'b1;
                brk_next   = BRK_CR;
            end
        end
        else if (b == CHAR_LF)
        begin
            if (brk_reg != BRK_CR)
            begin
                line_break = 1'b1;
                brk_next   = BRK_LF;
            end
        end
        else if (column_count_reg != COL_MAX)
        begin
            column_count_next = column_count_reg + COLUMN_BITS'(1);
        end
        if (line_break)
        begin
            column_count_next = '0;
            if (line_count_reg != LINE_MAX)
                line_count_next = line_count_reg + LINE_BITS'(1);
        end

        if (eof)
        begin
            active_next       = 1'b0;
            open_class_next   = CL_UNDEF;
            start_offset_next = '0;
            start_line_next   = LINE_BITS'(1);
            start_column_next = '0;
            tok_len_next      = '0;
            byte_offset_next  = '0;
            line_count_next   = LINE_BITS'(1);
            column_count_next = '0;
            brk_next          = BRK_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            stage_item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            active_reg       <= 1'b0;
            open_class_reg   <= CL_UNDEF;
            start_offset_reg <= '0;
            start_line_reg   <= LINE_BITS'(1);
            start_column_reg <= '0;
            tok_len_reg      <= '0;
            byte_offset_reg  <= '0;
            line_count_reg   <= LINE_BITS'(1);
            column_count_reg <= '0;
            brk_reg          <= BRK_NONE;
        end
        else
        begin
            if (!in_stall)
                stage_valid_reg <= in_valid;
            if (proceed)
            begin
                active_reg       <= active_next;
                open_class_reg   <= open_class_next;
                start_offset_reg <= start_offset_next;
                start_line_reg   <= start_line_next;
                start_column_reg <= start_column_next;
                tok_len_reg      <= tok_len_next;
                byte_offset_reg  <= byte_offset_next;
                line_count_reg   <= line_count_next;
                column_count_reg <= column_count_next;
                brk_reg          <= brk_next;
            end
        end
    end

endmodule

>>> rtl/ctb_token_fifo.sv
// Small token queue between the scan stage and the output channel; takes up to
// two tokens per cycle and hands out one per transfer. Uses ctb_pkg.
module ctb_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  ctb_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output ctb_pkg::token_t out_data
);
    import ctb_pkg::*;

    token_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic [FIFO_AW-1:0] wr_idx_b;
    logic               pop;
    logic [FIFO_AW:0]   n_push;

    assign room      = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        n_push      = (FIFO_AW+1)'(push.push_a) + (FIFO_AW+1)'(push.push_b);
        wr_idx_b    = wr_ptr_reg + FIFO_AW'(push.push_a);
        wr_ptr_next = wr_ptr_reg + n_push[FIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + n_push - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
            mem_reg[wr_ptr_reg] <= push.tok_a;
        if (push.push_b)
            mem_reg[wr_idx_b] <= push.tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
